### hdl/gla_pkg.sv
// ---------------------------------------------------------------------------
// gla_pkg
// Shared types and constants for the gated loudness accumulator.
// ---------------------------------------------------------------------------
package gla_pkg;

    localparam int CFG_W = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ABS_FLOOR    = 2'd2;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam int DIV_W = 64;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_CHECK,
        ST_BDIV,
        ST_GATE,
        ST_GMUL,
        ST_GDIV,
        ST_GSTORE,
        ST_NEXT,
        ST_UDIV,
        ST_OUT
    } state_t;

    // divider command/status
    typedef struct packed {
        logic            start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } div_cmd_t;

    typedef struct packed {
        logic            done;
        logic [DIV_W-1:0] quo;
    } div_sts_t;

endpackage

### hdl/gla_divider.sv
// ---------------------------------------------------------------------------
// gla_divider
// Restoring divider, one quotient bit per cycle, shared by all means.
// ---------------------------------------------------------------------------
module gla_divider
(
    input  logic               clk,
    input  logic               rst_n,
    input  gla_pkg::div_cmd_t  cmd,
    output gla_pkg::div_sts_t  sts
);

    localparam int W = gla_pkg::DIV_W;

    logic [W-1:0]       quo_reg;
    logic [W-1:0]       rem_reg;
    logic [W-1:0]       den_reg;
    logic [6:0]         cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [W:0]         trial;
    logic [W:0]         shifted;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign trial   = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            quo_reg <= cmd.num;
            rem_reg <= '0;
            den_reg <= cmd.den;
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                rem_reg <= trial[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    assign sts.done = done_reg;
    assign sts.quo  = quo_reg;

endmodule

### hdl/gated_loudness_accumulator.sv
// ---------------------------------------------------------------------------
// gated_loudness_accumulator
// Block-gated mean square meter with a shared iterative divider.
// ---------------------------------------------------------------------------
// A sample is squared and added into each block it has reached; each closing
// block takes a divider pass for its mean and, if it passes the gate with a
// nonzero gated mean, another for the gated mean; a last pass gives the
// ungated mean. A clear skips the divider. Input is taken only in ST_IDLE
// once the last result has been taken. Reset is asynchronous; control state,
// accumulators and outputs clear and config registers take defaults.
module gated_loudness_accumulator
#(
    parameter int NUM_BLOCKS     = 4,
    parameter int SAMPLE_BITS    = 24,
    parameter int BLOCK_LEN_BITS = 17
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // sample_value
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // opcode
    input  logic          s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // gated_mean_square, ungated_mean_square, accepted_blocks,
    // blocks_closed, blocks_accepted_now
    output logic [103:0]  m_axis_tdata
);

    localparam int SUM_W = BLOCK_LEN_BITS + 32;
    localparam int BI_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam logic [BLOCK_LEN_BITS-1:0] CNT_MAX = '1;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    logic [16:0] block_length_reg;
    logic [14:0] start_offset_reg;
    logic [31:0] abs_floor_reg;

    logic [SUM_W-1:0]          sums_reg [NUM_BLOCKS];
    logic [BLOCK_LEN_BITS-1:0] cnts_reg [NUM_BLOCKS];
    logic [31:0] gmean_reg, acc_cnt_reg, total_n_reg;
    logic [63:0] total_sq_reg;
    logic [32:0] sq_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [BI_W-1:0] idx_reg;
    logic [31:0] mean_reg;
    logic [63:0] prod_reg;
    logic [31:0] umean_reg;
    logic [2:0]  closed_reg, accnow_reg;
    logic        out_valid_reg;
    logic [47:0] off_reg;

    gla_pkg::state_t state_reg, state_next;
    gla_pkg::div_cmd_t div_cmd;
    gla_pkg::div_sts_t div_sts;

    gla_divider u_div (.clk(clk), .rst_n(rst_n), .cmd(div_cmd), .sts(div_sts));

    logic [SAMPLE_BITS-1:0] mag;
    logic [2*SAMPLE_BITS-1:0] mag_sq;
    logic [32:0] sq_trunc;
    logic [BLOCK_LEN_BITS-1:0] cur_cnt;
    logic [SUM_W-1:0] cur_sum;
    logic closes;
    logic [35:0] mean_x10;
    logic [31:0] div_mean;

    assign mag    = sample_reg[SAMPLE_BITS-1] ? (~sample_reg + 1'b1) : sample_reg;
    assign mag_sq = mag * mag;
    generate
        if (2*SAMPLE_BITS >= 34)
        begin : g_shr
            assign sq_trunc = 33'(mag_sq >> (2*SAMPLE_BITS-34));
        end
        else
        begin : g_shl
            assign sq_trunc = 33'({1'b0, mag_sq} << (34-2*SAMPLE_BITS));
        end
    endgenerate

    assign cur_cnt = cnts_reg[idx_reg];
    assign cur_sum = sums_reg[idx_reg];
    assign closes  = (block_length_reg != '0)
                   && (32'(cur_cnt) >= 32'(block_length_reg));
    assign div_mean = (div_sts.quo[63:32] != '0) ? 32'hFFFF_FFFF : div_sts.quo[31:0];
    assign mean_x10 = {mean_reg, 3'b000} + {3'b000, mean_reg, 1'b0};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gla_pkg::ST_IDLE:
                if (s_axis_tvalid && s_axis_tready)
                    state_next = (s_axis_tuser == gla_pkg::OP_CLEAR) ? gla_pkg::ST_UDIV
                                                                   : gla_pkg::ST_SQUARE;
            gla_pkg::ST_SQUARE: state_next = gla_pkg::ST_ACCUM;
            gla_pkg::ST_ACCUM:
                if (idx_reg == BI_W'(NUM_BLOCKS-1))
                    state_next = gla_pkg::ST_CHECK;
            gla_pkg::ST_CHECK:  state_next = closes ? gla_pkg::ST_BDIV : gla_pkg::ST_NEXT;
            gla_pkg::ST_BDIV:   if (div_sts.done) state_next = gla_pkg::ST_GATE;
            gla_pkg::ST_GATE:
                if (mean_reg <= abs_floor_reg || mean_x10 <= {4'd0, gmean_reg})
                    state_next = gla_pkg::ST_NEXT;
                else if (gmean_reg == '0)
                    state_next = gla_pkg::ST_GSTORE;
                else
                    state_next = gla_pkg::ST_GMUL;
            gla_pkg::ST_GMUL:   state_next = gla_pkg::ST_GDIV;
            gla_pkg::ST_GDIV:   if (div_sts.done) state_next = gla_pkg::ST_GSTORE;
            gla_pkg::ST_GSTORE: state_next = gla_pkg::ST_NEXT;
            gla_pkg::ST_NEXT:
                state_next = (idx_reg == BI_W'(NUM_BLOCKS-1)) ? gla_pkg::ST_UDIV
                                                             : gla_pkg::ST_CHECK;
            gla_pkg::ST_UDIV:
                if (total_n_reg == '0 || div_sts.done)
                    state_next = gla_pkg::ST_OUT;
            gla_pkg::ST_OUT:    if (!out_valid_reg) state_next = gla_pkg::ST_IDLE;
            default:            state_next = gla_pkg::ST_IDLE;
        endcase
    end

    logic udiv_started_reg;

    always_comb
    begin
        div_cmd = '0;
        unique case (state_reg)
            gla_pkg::ST_CHECK:
                if (closes)
                begin
                    div_cmd.start = 1'b1;
                    div_cmd.num   = 64'(cur_sum);
                    div_cmd.den   = 64'(cur_cnt);
                end
            gla_pkg::ST_GMUL:
            begin
                div_cmd.start = 1'b1;
                div_cmd.num   = prod_reg + 64'(mean_reg);
                div_cmd.den   = 64'(acc_cnt_reg) + 64'd1;
            end
            gla_pkg::ST_UDIV:
                if (!udiv_started_reg && total_n_reg != '0)
                begin
                    div_cmd.start = 1'b1;
                    div_cmd.num   = total_sq_reg;
                    div_cmd.den   = 64'(total_n_reg);
                end
            default: div_cmd = '0;
        endcase
    end

    assign s_axis_tready = (state_reg == gla_pkg::ST_IDLE) && !out_valid_reg;
    assign m_axis_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= gla_pkg::ST_IDLE;
            block_length_reg <= 17'd19200;
            start_offset_reg <= 15'd4800;
            abs_floor_reg    <= 32'd504;
            for (int i = 0; i < NUM_BLOCKS; i++)
            begin
                sums_reg[i] <= '0;
                cnts_reg[i] <= '0;
            end
            gmean_reg        <= '0;
            acc_cnt_reg      <= '0;
            total_n_reg      <= '0;
            total_sq_reg     <= '0;
            idx_reg          <= '0;
            off_reg          <= '0;
            closed_reg       <= '0;
            accnow_reg       <= '0;
            out_valid_reg    <= 1'b0;
            udiv_started_reg <= 1'b0;
            umean_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    gla_pkg::REG_BLOCK_LENGTH: block_length_reg <= cfg_data[16:0];
                    gla_pkg::REG_START_OFFSET: start_offset_reg <= cfg_data[14:0];
                    gla_pkg::REG_ABS_FLOOR:    abs_floor_reg    <= cfg_data;
                    default: ;
                endcase
                if (cfg_index == gla_pkg::REG_BLOCK_LENGTH
                    || cfg_index == gla_pkg::REG_START_OFFSET)
                    for (int i = 0; i < NUM_BLOCKS; i++)
                    begin
                        sums_reg[i] <= '0;
                        cnts_reg[i] <= '0;
                    end
            end
            unique case (state_reg)
                gla_pkg::ST_IDLE:
                begin
                    idx_reg          <= '0;
                    off_reg          <= '0;
                    closed_reg       <= '0;
                    accnow_reg       <= '0;
                    udiv_started_reg <= 1'b0;
                    if (s_axis_tvalid && s_axis_tready
                        && s_axis_tuser == gla_pkg::OP_CLEAR)
                    begin
                        for (int i = 0; i < NUM_BLOCKS; i++)
                        begin
                            sums_reg[i] <= '0;
                            cnts_reg[i] <= '0;
                        end
                        gmean_reg    <= '0;
                        acc_cnt_reg  <= '0;
                        total_n_reg  <= '0;
                        total_sq_reg <= '0;
                    end
                end
                gla_pkg::ST_SQUARE:
                begin
                    if (total_sq_reg > ~64'(sq_trunc))
                        total_sq_reg <= '1;
                    else
                        total_sq_reg <= total_sq_reg + 64'(sq_trunc);
                end
                gla_pkg::ST_ACCUM:
                begin
                    // add into block idx once the sample count reaches its offset
                    if ({16'd0, total_n_reg} >= off_reg)
                    begin
                        if ({16'd0, cur_sum} > {16'd0, SUM_MAX} - 65'(sq_reg))
                            sums_reg[idx_reg] <= SUM_MAX;
                        else
                            sums_reg[idx_reg] <= cur_sum + SUM_W'(sq_reg);
                        if (cur_cnt != CNT_MAX)
                            cnts_reg[idx_reg] <= cur_cnt + 1'b1;
                    end
                    off_reg <= off_reg + 48'(start_offset_reg);
                    if (idx_reg == BI_W'(NUM_BLOCKS-1))
                        idx_reg <= '0;
                    else
                        idx_reg <= idx_reg + BI_W'(1);
                end
                gla_pkg::ST_CHECK:
                    if (closes)
                    begin
                        closed_reg        <= closed_reg + 3'd1;
                        sums_reg[idx_reg] <= '0;
                        cnts_reg[idx_reg] <= '0;
                    end
                gla_pkg::ST_BDIV:
                    if (div_sts.done)
                        mean_reg <= div_mean;
                gla_pkg::ST_GATE:
                    prod_reg <= acc_cnt_reg * gmean_reg;
                gla_pkg::ST_GDIV:
                    if (div_sts.done)
                        mean_reg <= div_sts.quo[31:0];
                gla_pkg::ST_GSTORE:
                begin
                    gmean_reg  <= mean_reg;
                    accnow_reg <= accnow_reg + 3'd1;
                    if (acc_cnt_reg != 32'hFFFF_FFFF)
                        acc_cnt_reg <= acc_cnt_reg + 32'd1;
                end
                gla_pkg::ST_NEXT:
                begin
                    if (idx_reg == BI_W'(NUM_BLOCKS-1))
                    begin
                        idx_reg <= '0;
                        if (total_n_reg != 32'hFFFF_FFFF)
                            total_n_reg <= total_n_reg + 32'd1;
                    end
                    else
                        idx_reg <= idx_reg + BI_W'(1);
                end
                gla_pkg::ST_UDIV:
                begin
                    udiv_started_reg <= 1'b1;
                    if (total_n_reg == '0)
                        umean_reg <= '0;
                    else if (div_sts.done)
                        umean_reg <= div_mean;
                end
                gla_pkg::ST_OUT:
                    if (!out_valid_reg && state_next == gla_pkg::ST_IDLE)
                        out_valid_reg <= 1'b0;
                    else if (!out_valid_reg)
                        out_valid_reg <= 1'b1;
                default: ;
            endcase
            if (state_reg == gla_pkg::ST_UDIV && state_next == gla_pkg::ST_OUT)
                out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            sample_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
        if (state_reg == gla_pkg::ST_SQUARE)
            sq_reg <= sq_trunc;
    end

    assign m_axis_tdata = {2'b00, accnow_reg, closed_reg, acc_cnt_reg, umean_reg, gmean_reg};

endmodule

### hdl/gla_checker.sv
// ---------------------------------------------------------------------------
// gla_checker
// Port-level checks for the gated loudness accumulator.
// ---------------------------------------------------------------------------
module gla_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [103:0] m_axis_tdata
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");

    a_acc_le_closed: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[101:99] <= m_axis_tdata[98:96])
        else $error("more accepted than closed");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
        else $error("result before work done");

endmodule

bind gated_loudness_accumulator gla_checker u_gla_checker
(
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
